[hw/rtl/lrp_pkg.sv]
// ----------------------------------------------------------------------------
// lrp_pkg
// Types and codes shared by the lineage record parser modules.
// ----------------------------------------------------------------------------
package lrp_pkg;

	// kind of item completed by one byte
	typedef enum logic [2:0] {
		KIND_PARTIAL  = 3'd0,
		KIND_NAME     = 3'd1,
		KIND_SOURCE   = 3'd2,
		KIND_REVISION = 3'd3,
		KIND_ARGUMENT = 3'd4
	} item_kind_t;

	// record verdict, reported on the final byte only
	typedef enum logic [1:0] {
		STATUS_PENDING  = 2'd0,
		STATUS_ACCEPTED = 2'd1,
		STATUS_REFUSED  = 2'd2
	} record_status_t;

	// layout codes of the first byte
	localparam logic [7:0] LAYOUT_PLAIN  = 8'd1;
	localparam logic [7:0] LAYOUT_RESULT = 8'd2;
	localparam logic [7:0] LAYOUT_RERUN  = 8'd3;

	// parser phase, one-hot
	typedef enum logic [9:0] {
		PH_LAYOUT  = 10'b00_0000_0001,
		PH_NAMELEN = 10'b00_0000_0010,
		PH_NAME    = 10'b00_0000_0100,
		PH_COUNT   = 10'b00_0000_1000,
		PH_KEYS    = 10'b00_0001_0000,
		PH_REVS    = 10'b00_0010_0000,
		PH_ARGLEN  = 10'b00_0100_0000,
		PH_ARGS    = 10'b00_1000_0000,
		PH_DONE    = 10'b01_0000_0000,
		PH_SKIP    = 10'b10_0000_0000
	} phase_t;

	// one result transaction
	typedef struct packed {
		item_kind_t     kind;
		logic [63:0]    value;
		logic [31:0]    index;
		record_status_t status;
	} result_t;

endpackage

[hw/rtl/lrp_in_if.sv]
// ----------------------------------------------------------------------------
// lrp_in_if
// Byte stream channel into the lineage record parser.
// ----------------------------------------------------------------------------
interface lrp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

[hw/rtl/lrp_out_if.sv]
// ----------------------------------------------------------------------------
// lrp_out_if
// Result channel out of the lineage record parser.
// ----------------------------------------------------------------------------
interface lrp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  item_kind;
	logic [63:0] item_value;
	logic [31:0] item_index;
	logic [1:0]  record_status;

	modport source (output valid, output item_kind, output item_value,
		output item_index, output record_status, input ready);
	modport sink   (input valid, input item_kind, input item_value,
		input item_index, input record_status, output ready);
endinterface

[hw/rtl/lrp_core.sv]
// ----------------------------------------------------------------------------
// lrp_core
// Parser state registers and the per-byte step logic.
// ----------------------------------------------------------------------------
module lrp_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       data_byte,
	input  logic             final_byte,
	output lrp_pkg::result_t res
);
	import lrp_pkg::*;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  layout;
		logic [2:0]  biw;
		logic [63:0] word;
		logic [31:0] rem;
		logic [31:0] count;
		logic [31:0] pos;
		logic        refused;
	} state_t;

	localparam state_t ST_RESET = '{phase: PH_LAYOUT, layout: 2'd0, biw: 3'd0,
		word: 64'd0, rem: 32'd0, count: 32'd0, pos: 32'd0, refused: 1'b0};

	state_t st_q;
	state_t nx;

	logic [63:0] wacc;
	logic [2:0]  biw_inc;
	logic [31:0] rem_dec;

	// enter a new field with a fresh word and position
	function automatic state_t to_field(state_t s, phase_t p, logic [31:0] n);
		state_t r;
		r       = s;
		r.phase = p;
		r.rem   = n;
		r.pos   = 32'd0;
		r.biw   = 3'd0;
		r.word  = 64'd0;
		return r;
	endfunction

	function automatic state_t refuse(state_t s);
		state_t r;
		r         = s;
		r.refused = 1'b1;
		return to_field(r, PH_SKIP, 32'd0);
	endfunction

	// last item of a counted field seen
	function automatic state_t field_over(state_t s);
		state_t r;
		r = s;
		unique case (s.phase)
			PH_NAME: r = to_field(s, PH_COUNT, 32'd0);
			PH_KEYS: begin
				if (s.layout >= LAYOUT_RESULT[1:0]) r = to_field(s, PH_REVS, s.count);
				else r = to_field(s, PH_DONE, 32'd0);
			end
			PH_REVS: begin
				if (s.layout == LAYOUT_RERUN[1:0]) r = to_field(s, PH_ARGLEN, 32'd0);
				else r = to_field(s, PH_DONE, 32'd0);
			end
			default: r = to_field(s, PH_DONE, 32'd0);
		endcase
		return r;
	endfunction

	// a 32-bit length or count word completed
	function automatic state_t length_done(state_t s, logic [31:0] v);
		state_t r;
		r = s;
		unique case (s.phase)
			PH_NAMELEN: begin
				if (v == 32'd0) r = to_field(s, PH_COUNT, 32'd0);
				else r = to_field(s, PH_NAME, v);
			end
			PH_COUNT: begin
				r.count = v;
				if (v == 32'd0) begin
					if (s.layout >= LAYOUT_RESULT[1:0]) r = refuse(r);
					else r = to_field(r, PH_DONE, 32'd0);
				end else begin
					r = to_field(r, PH_KEYS, v);
				end
			end
			default: begin
				if (v == 32'd0) r = refuse(s);
				else r = to_field(s, PH_ARGS, v);
			end
		endcase
		return r;
	endfunction

	// byte step
	always_comb begin
		nx         = st_q;
		res.kind   = KIND_PARTIAL;
		res.value  = 64'd0;
		res.index  = 32'd0;
		res.status = STATUS_PENDING;
		wacc       = st_q.word | (64'(data_byte) << {st_q.biw, 3'b000});
		biw_inc    = st_q.biw + 3'd1;
		rem_dec    = st_q.rem - 32'd1;

		unique case (st_q.phase)
			PH_LAYOUT: begin
				if (data_byte >= LAYOUT_PLAIN && data_byte <= LAYOUT_RERUN) begin
					nx.layout = data_byte[1:0];
					nx = to_field(nx, PH_NAMELEN, 32'd0);
				end else begin
					nx = refuse(nx);
				end
			end
			PH_NAMELEN, PH_COUNT, PH_ARGLEN: begin
				nx.word = wacc;
				nx.biw  = biw_inc;
				if (biw_inc == 3'd4) nx = length_done(nx, wacc[31:0]);
			end
			PH_NAME, PH_ARGS: begin
				res.kind  = (st_q.phase == PH_NAME) ? KIND_NAME : KIND_ARGUMENT;
				res.value = 64'(data_byte);
				res.index = st_q.pos;
				nx.pos    = st_q.pos + 32'd1;
				nx.rem    = rem_dec;
				if (rem_dec == 32'd0) nx = field_over(nx);
			end
			PH_KEYS, PH_REVS: begin
				nx.word = wacc;
				nx.biw  = biw_inc;
				if (biw_inc == 3'd0) begin
					res.kind  = (st_q.phase == PH_KEYS) ? KIND_SOURCE : KIND_REVISION;
					res.value = wacc;
					res.index = st_q.pos;
					nx.word   = 64'd0;
					nx.pos    = st_q.pos + 32'd1;
					nx.rem    = rem_dec;
					if (rem_dec == 32'd0) nx = field_over(nx);
				end
			end
			PH_DONE, PH_SKIP: nx = refuse(nx);
			default: nx = refuse(nx);
		endcase

		// verdict and return to reset state on the final byte
		if (final_byte) begin
			res.status = (nx.phase == PH_DONE && !nx.refused) ? STATUS_ACCEPTED
				: STATUS_REFUSED;
			nx = ST_RESET;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (take) begin
			st_q <= nx;
		end
	end

	// a final byte always leaves the parser ready for a new record
	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take && final_byte |=> st_q.phase == PH_LAYOUT && !st_q.refused)
		else $error("parser not reset after final byte");

	// refusal only ever parks the parser in the skip phase
	a_refused_skip: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.refused |-> st_q.phase == PH_SKIP)
		else $error("refused flag outside skip phase");

	// length words never pass their fourth byte
	a_length_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_NAMELEN || st_q.phase == PH_COUNT || st_q.phase == PH_ARGLEN)
		|-> st_q.biw < 3'd4)
		else $error("length word overran four bytes");

endmodule

[hw/rtl/lineage_record_parser.sv]
// ----------------------------------------------------------------------------
// lineage_record_parser
// Byte-serial parser for serialized lineage records.
// ----------------------------------------------------------------------------
// The rec channel takes one record byte per transaction, with final_byte set
// on the last byte of the record. For every byte the items channel delivers
// exactly one transaction: the item that byte completes (name byte, source
// key, revision or argument byte) or a partial marker, and on the final byte
// the record verdict, accepted or refused.
// Each accepted byte's result is registered in the result or skid register.
// Throughput is one byte per cycle while rec is ready; the step logic
// updates a few counters and the phase, between state and result registers.
// A two-entry output buffer (result register plus skid register) keeps rec
// ready while one result waits; rec drops ready only when both are full, so
// a stalled receiver holds back at most two results before input stops.
// After the final byte the parser is back in its reset state for the next
// record. Reset clears the parser state and empties the output buffer.
// ----------------------------------------------------------------------------
module lineage_record_parser (
	input  logic   clk,
	input  logic   arst_n,
	lrp_in_if.sink   rec,
	lrp_out_if.source items
);
	import lrp_pkg::*;

	result_t res;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    take;
	logic    pop;

	assign rec.ready = !skid_valid_q;
	assign take      = rec.valid && !skid_valid_q;
	assign pop       = out_valid_q && items.ready;

	lrp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (rec.data_byte),
		.final_byte (rec.final_byte),
		.res        (res)
	);

	// output buffer occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) skid_valid_q <= 1'b0;
		end else if (take) begin
			if (out_valid_q && !pop) skid_valid_q <= 1'b1;
			else out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (take) begin
			if (out_valid_q && !pop) skid_q <= res;
			else out_q <= res;
		end
	end

	assign items.valid         = out_valid_q;
	assign items.item_kind     = out_q.kind;
	assign items.item_value    = out_q.value;
	assign items.item_index    = out_q.index;
	assign items.record_status = out_q.status;

	// the skid register is only used behind a full result register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without result entry");

	// a transaction arriving on a stalled full result register goes to skid
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		take && out_valid_q && !items.ready |=> skid_valid_q && out_valid_q)
		else $error("result lost on stall");

	// a delivered result lets the skid entry move up
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && pop |=> !skid_valid_q && out_valid_q)
		else $error("skid entry not moved to result register");

endmodule
